[design/mhve_pkg.sv]
// Package for the mail header value extractor: types, constants and helpers.
`default_nettype none
package mhve_pkg;

	localparam int MAX_NAME_LEN = 16;
	localparam int LEN_W        = 5;
	localparam int CNT_W        = 4;
	localparam int CHARS_W      = 8 * MAX_NAME_LEN;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [31:0] END_CRLFCRLF = 32'h0D0A_0D0A;
	localparam logic [15:0] END_LFLF     = 16'h0A0A;
	localparam logic [15:0] END_CRCR     = 16'h0D0D;

	// Configuration register indexes.
	localparam logic [1:0] REG_NAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_CHARS_LOW   = 2'd1;
	localparam logic [1:0] REG_CHARS_HIGH  = 2'd2;

	typedef enum logic [5:0] {
		PH_MATCH    = 6'b000001,
		PH_SKIPLINE = 6'b000010,
		PH_EOLRUN   = 6'b000100,
		PH_SEP      = 6'b001000,
		PH_VALUE    = 6'b010000,
		PH_IDLE     = 6'b100000
	} phase_t;

	// What one byte does to the search state, and the result it produces.
	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] matched;
		logic [31:0]      recent;
		logic             emit;
		logic             done;
		logic             found;
	} step_out_t;

	// ASCII upper case letters fold to lower case.
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'h20;
		return r;
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage
`default_nettype wire

[design/mhve_step.sv]
// Per-byte search step: phase update, name compare and result decision.
`default_nettype none
module mhve_step (
	input  wire mhve_pkg::phase_t                phase,
	input  wire logic [mhve_pkg::CNT_W-1:0]     matched,
	input  wire logic [31:0]                    recent,
	input  wire logic [7:0]                     text_byte,
	input  wire logic                           final_byte,
	input  wire logic [mhve_pkg::LEN_W-1:0]     name_len,
	input  wire logic [mhve_pkg::CHARS_W-1:0]   name_chars,
	output mhve_pkg::step_out_t                 res
);
	import mhve_pkg::*;

	phase_t           ph;
	logic [CNT_W-1:0] m;
	logic [LEN_W-1:0] m_inc;
	logic             to_sep;
	logic             emit;
	logic             done;
	logic             found;
	logic             eol;
	logic             terminator;
	logic [7:0]       name_ch;

	assign eol        = is_eol(text_byte);
	assign terminator = (recent == END_CRLFCRLF) || (recent[15:0] == END_LFLF) ||
		(recent[15:0] == END_CRCR);

	always_comb begin
		ph      = phase;
		m       = matched;
		to_sep  = 1'b0;
		emit    = 1'b0;
		done    = 1'b0;
		found   = 1'b0;
		name_ch = name_chars[{m, 3'b000} +: 8];
		m_inc   = {1'b0, m} + LEN_W'(1);

		if (phase == PH_SKIPLINE && eol)
			ph = PH_EOLRUN;

		// A non line-end byte closes the line-end run: either the block
		// ends, or the byte is the first of a new line.
		if (phase == PH_EOLRUN && !eol) begin
			if (terminator) begin
				done = 1'b1;
				ph   = PH_IDLE;
			end else begin
				ph = PH_MATCH;
				m  = '0;
			end
		end

		if (ph == PH_MATCH) begin
			name_ch = name_chars[{m, 3'b000} +: 8];
			m_inc   = {1'b0, m} + LEN_W'(1);
			if (name_len == '0) begin
				ph     = PH_SEP;
				to_sep = 1'b1;
			end else if (fold(text_byte) == fold(name_ch)) begin
				if (m_inc >= name_len) begin
					m  = '0;
					ph = PH_SEP;
				end else begin
					m = m_inc[CNT_W-1:0];
				end
			end else begin
				m  = '0;
				ph = eol ? PH_EOLRUN : PH_SKIPLINE;
			end
		end

		if (phase == PH_SEP || to_sep) begin
			if (text_byte == CH_COLON || text_byte == CH_SPACE || text_byte == CH_TAB) begin
				ph = PH_SEP;
			end else if (eol) begin
				done  = 1'b1;
				found = 1'b1;
				ph    = PH_IDLE;
			end else begin
				emit = 1'b1;
				ph   = PH_VALUE;
				if (final_byte) begin
					done  = 1'b1;
					found = 1'b1;
				end
			end
		end

		if (phase == PH_VALUE) begin
			if (eol) begin
				done  = 1'b1;
				found = 1'b1;
				ph    = PH_IDLE;
			end else begin
				emit = 1'b1;
				if (final_byte) begin
					done  = 1'b1;
					found = 1'b1;
				end
			end
		end

		res.recent = {recent[23:0], text_byte};

		// The final byte always closes the search and rearms for a new text.
		if (final_byte) begin
			if (!done && phase != PH_IDLE) begin
				done  = 1'b1;
				found = 1'b0;
			end
			ph         = PH_MATCH;
			m          = '0;
			res.recent = '0;
		end

		res.phase   = ph;
		res.matched = m;
		res.emit    = emit;
		res.done    = done;
		res.found   = done && found;
	end

endmodule
`default_nettype wire

[design/mail_header_value_extractor.sv]
// Top level of the mail header value extractor: stream ports, registers and control.
// A byte accepted into the input register yields its result beat from the result
// register; bytes that cause no result vanish.
// Throughput: one byte per cycle while the output does not stall, set by the step
// logic between the input and result registers; the output waits only on tready.
// Reset (arst_n low, asynchronous): search state returns to matching at line start,
// both stream registers empty, name_length reads 1 and the name characters 0.
`default_nettype none
module mail_header_value_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream: tdata = text_byte[7:0]; tlast = final_byte.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tlast,
	// Output stream: tdata = value_byte[7:0]; tlast = search_done.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast,
	// tuser bit 0 = byte_valid, bit 1 = header_found.
	output logic [1:0]       m_axis_tuser,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import mhve_pkg::*;

	// Configuration registers.
	logic [LEN_W-1:0] name_length_q;
	logic [63:0]      chars_low_q;
	logic [63:0]      chars_high_q;
	logic [LEN_W-1:0] len_sat;

	// Search state.
	phase_t           phase_q;
	logic [CNT_W-1:0] matched_q;
	logic [31:0]      recent_q;

	// Input register.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             fin_s1;

	// Result register.
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_bvalid_q;
	logic             out_done_q;
	logic             out_found_q;

	step_out_t        step;
	logic             has_result;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= LEN_W'(1);
			chars_low_q   <= '0;
			chars_high_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NAME_LENGTH: name_length_q <= cfg_data[LEN_W-1:0];
				REG_CHARS_LOW:   chars_low_q   <= cfg_data;
				REG_CHARS_HIGH:  chars_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Lengths above the name buffer size act as a full-length name.
	assign len_sat = (name_length_q > LEN_W'(MAX_NAME_LEN)) ?
		LEN_W'(MAX_NAME_LEN) : name_length_q;

	mhve_step u_step (
		.phase      (phase_q),
		.matched    (matched_q),
		.recent     (recent_q),
		.text_byte  (byte_s1),
		.final_byte (fin_s1),
		.name_len   (len_sat),
		.name_chars ({chars_high_q, chars_low_q}),
		.res        (step)
	);

	// A byte leaves the input register when its result has a place to go;
	// a byte with no result never waits on the output side.
	assign has_result    = step.emit || step.done;
	assign advance       = valid_s1 && (!has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			fin_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MATCH;
			matched_q <= '0;
			recent_q  <= '0;
		end else if (advance) begin
			phase_q   <= step.phase;
			matched_q <= step.matched;
			recent_q  <= step.recent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_byte_q   <= step.emit ? byte_s1 : 8'h00;
			out_bvalid_q <= step.emit;
			out_done_q   <= step.done;
			out_found_q  <= step.found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_done_q;
	assign m_axis_tuser  = {out_found_q, out_bvalid_q};

	// Every result beat carries a value byte or ends the search.
	a_beat_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
		else $error("result beat with neither value byte nor done");

	// Found is only reported on the beat that ends the search.
	a_found_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
		else $error("header_found without search_done");

	// A beat without a value byte carries a zero data byte.
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
		else $error("nonzero value byte on a beat without byte_valid");

	// After the final byte of a text the search rearms at a line start.
	a_final_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fin_s1) |=> (phase_q == PH_MATCH && matched_q == '0 && recent_q == '0))
		else $error("search state not rearmed after final byte");

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking stream testbench for the mail header value extractor.
`timescale 1ns / 1ps
module testbench;
	import mhve_pkg::*;

	// One result beat, in the order of the result fields.
	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       search_done;
		logic       header_found;
	} header_beat_t;

	// Stall patterns of the result receiver.
	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_PERIODIC,
		RX_STARVED
	} rx_mode_t;

	// A row of the directed script either loads a new header name or sends one byte.
	// A row with typed set carries its result beat written out by hand.
	typedef struct {
		bit           load;
		logic [4:0]   len;
		logic [63:0]  chars_lo;
		logic [63:0]  chars_hi;
		logic [7:0]   text;
		bit           last;
		bit           typed;
		header_beat_t want;
	} script_row_t;

	localparam header_beat_t NO_BEAT    = '0;
	localparam header_beat_t NOT_FOUND  = '{8'h00, 1'b0, 1'b1, 1'b0};
	localparam header_beat_t FOUND_DONE = '{8'h00, 1'b0, 1'b1, 1'b1};
	localparam int SCRIPT_ROWS   = 33;
	localparam int RANDOM_TARGET = 600;
	localparam int PHASE_BYTES   = 60;
	// Edges that quiesce waits after the last expected beat, before a name write.
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_NAME_LENGTH;
	logic [63:0] cfg_data = 64'h0;

	mail_header_value_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		// tdata = text_byte[7:0]; tlast = final_byte.
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		// tdata = value_byte[7:0]; tlast = search_done.
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		// tuser bit 0 = byte_valid, bit 1 = header_found.
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow copy of the name registers, at their reset values.
	logic [4:0]  name_len_reg = 5'd1;
	logic [63:0] name_lo = 64'h0;
	logic [63:0] name_hi = 64'h0;

	// Search state that the predictor keeps in step with the block.
	phase_t      scan_phase = PH_MATCH;
	int unsigned match_pos = 0;
	logic [31:0] last_four = 32'h0;

	header_beat_t pending_beats[$];
	logic [7:0]   text_bytes[$];
	int unsigned  fail_count = 0;
	int unsigned  beats_seen = 0;
	int unsigned  live_bytes = 0;
	int unsigned  burst_left = 0;

	// The directed script. Names are packed with the first character in the lowest byte.
	script_row_t script [SCRIPT_ROWS] = '{
		// Reset name: one character, the zero byte. A zero byte matches, a value follows
		// and ends on the final byte, so the byte and the done flag share one beat.
		'{1'b0, 5'd0, 64'h0, 64'h0, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "v", 1'b1, 1'b1, '{"v", 1'b1, 1'b1, 1'b1}},
		// A match that ends on the final byte is a miss.
		'{1'b0, 5'd0, 64'h0, 64'h0, 8'h00, 1'b1, 1'b1, NOT_FOUND},
		'{1'b0, 5'd0, 64'h0, 64'h0, 8'hFF, 1'b1, 1'b1, NOT_FOUND},
		// Name "To", matched in mixed case, then colon and tab separators.
		'{1'b1, 5'd2, 64'h6F54, 64'h0, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "t", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "O", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_COLON, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_TAB, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "a", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_CR, 1'b0, 1'b1, FOUND_DONE},
		// After the done beat, bytes are dropped up to the final one.
		'{1'b0, 5'd0, 64'h0, 64'h0, "x", 1'b1, 1'b0, NO_BEAT},
		// Empty value: the line ends right after the name.
		'{1'b0, 5'd0, 64'h0, 64'h0, "T", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "o", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_LF, 1'b1, 1'b1, FOUND_DONE},
		// Nothing but separators up to the final byte.
		'{1'b0, 5'd0, 64'h0, 64'h0, "T", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "o", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_COLON, 1'b1, 1'b1, NOT_FOUND},
		// A foreign line closed by CR LF CR LF ends the header block.
		'{1'b0, 5'd0, 64'h0, 64'h0, "Q", 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_CR, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_LF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_CR, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_LF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "T", 1'b1, 1'b1, NOT_FOUND},
		// Zero name length: every line start matches at once.
		'{1'b1, 5'd0, '1, '1, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_SPACE, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, "z", 1'b1, 1'b1, '{"z", 1'b1, 1'b1, 1'b1}},
		// Largest length field, which saturates to sixteen all-ones characters.
		'{1'b1, 5'd31, '1, '1, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, 8'h7F, 1'b1, 1'b1, NOT_FOUND},
		// A CR inside the name is an ordinary character and does not end the line.
		'{1'b1, 5'd1, 64'h0D, 64'h0, 8'h00, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_CR, 1'b0, 1'b0, NO_BEAT},
		'{1'b0, 5'd0, 64'h0, 64'h0, CH_CR, 1'b1, 1'b1, FOUND_DONE}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s", $realtime, msg);
	endfunction

	function automatic logic [7:0] ascii_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic bit line_break(input logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [7:0] name_byte(input int unsigned k);
		logic [127:0] chars;
		chars = {name_hi, name_lo};
		return chars[8 * (k % MAX_NAME_LEN) +: 8];
	endfunction

	// Advances the search by one byte. Returns 1 when the byte causes a result beat.
	function automatic bit search_step(input logic [7:0] b, input logic fin,
			output header_beat_t beat);
		int unsigned span;
		bit was_over, emit, done, found, again;
		span = (name_len_reg > MAX_NAME_LEN) ? MAX_NAME_LEN : name_len_reg;
		was_over = (scan_phase == PH_IDLE);
		emit = 1'b0;
		done = 1'b0;
		found = 1'b0;
		do begin
			again = 1'b0;
			case (scan_phase)
			PH_MATCH: begin
				if (span == 0) begin
					// An empty name matches at once; the byte is handled as a separator.
					scan_phase = PH_SEP;
					again = 1'b1;
				end else if (ascii_lower(b) == ascii_lower(name_byte(match_pos))) begin
					match_pos++;
					if (match_pos >= span) begin
						match_pos = 0;
						scan_phase = PH_SEP;
					end
				end else begin
					match_pos = 0;
					scan_phase = line_break(b) ? PH_EOLRUN : PH_SKIPLINE;
				end
			end
			PH_SKIPLINE: begin
				if (line_break(b))
					scan_phase = PH_EOLRUN;
			end
			PH_EOLRUN: begin
				if (!line_break(b)) begin
					// The run of line ends is over; a blank line closes the header block.
					if (last_four == END_CRLFCRLF || last_four[15:0] == END_LFLF ||
							last_four[15:0] == END_CRCR) begin
						done = 1'b1;
						scan_phase = PH_IDLE;
					end else begin
						scan_phase = PH_MATCH;
						match_pos = 0;
						again = 1'b1;
					end
				end
			end
			PH_SEP, PH_VALUE: begin
				if (scan_phase == PH_SEP &&
						(b == CH_COLON || b == CH_SPACE || b == CH_TAB)) begin
					// Separators before the value are skipped.
				end else if (line_break(b)) begin
					done = 1'b1;
					found = 1'b1;
					scan_phase = PH_IDLE;
				end else begin
					emit = 1'b1;
					scan_phase = PH_VALUE;
					if (fin) begin
						done = 1'b1;
						found = 1'b1;
					end
				end
			end
			default: begin
			end
			endcase
		end while (again);

		last_four = {last_four[23:0], b};
		if (fin) begin
			// The final byte always closes the search and starts a fresh text.
			if (!done && !was_over) begin
				done = 1'b1;
				found = 1'b0;
			end
			scan_phase = PH_MATCH;
			match_pos = 0;
			last_four = 32'h0;
		end
		beat = '{emit ? b : 8'h00, emit, done, done && found};
		return emit || done;
	endfunction

	// Sends one byte in the sender's burst pattern and records what it should produce.
	// Entered and left in the time step of a rising edge.
	task automatic send_text_byte(input logic [7:0] b, input logic fin, input bit typed,
			input header_beat_t want);
		int unsigned gap;
		header_beat_t beat;
		bit has_beat;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		// Inputs only change at rising edges, so tready seen at the falling edge is
		// the value that decides the handshake at the next rising edge.
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		live_bytes++;
		has_beat = search_step(b, fin, beat);
		if (typed) begin
			if (!has_beat || beat != want)
				note_failure($sformatf("script byte %h: written beat %h, search predicts %h",
					b, want, has_beat ? beat : NO_BEAT));
			pending_beats.push_back(want);
		end else if (has_beat) begin
			pending_beats.push_back(beat);
		end
	endtask

	// Holds the sender back until every expected beat has come and the pipeline is empty.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three name registers on consecutive edges.
	task automatic load_name(input logic [4:0] len, input logic [63:0] lo,
			input logic [63:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_NAME_LENGTH;
		cfg_data <= {59'd0, len};
		@(posedge clk);
		cfg_index <= REG_CHARS_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_CHARS_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		name_len_reg = len;
		name_lo = lo;
		name_hi = hi;
	endtask

	function automatic void push_line_end();
		int unsigned pick;
		pick = $urandom_range(0, 4);
		// Mostly CR LF, sometimes a bare LF or a bare CR.
		if (pick != 1)
			text_bytes.push_back(CH_CR);
		if (pick != 2)
			text_bytes.push_back(CH_LF);
	endfunction

	// Builds one header block in text_bytes: a few header lines, one of them usually
	// carrying the configured name, a blank line and maybe some body. A few blocks are
	// pure noise, and some are cut off at a random point.
	function automatic void compose_text();
		int unsigned span, lines, wanted, n, i, k;
		logic [7:0] c;
		text_bytes.delete();
		span = (name_len_reg > MAX_NAME_LEN) ? MAX_NAME_LEN : name_len_reg;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 24);
			repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		lines = $urandom_range(1, 4);
		// When wanted equals lines, the searched header is usually absent.
		wanted = $urandom_range(0, lines);
		for (i = 0; i < lines; i++) begin
			if (i == wanted || $urandom_range(0, 4) == 0) begin
				// The configured name in random letter case, sometimes broken off by a
				// byte that differs from the next name character.
				n = span;
				if (span > 0 && $urandom_range(0, 3) == 0)
					n = $urandom_range(0, span - 1);
				for (k = 0; k < n; k++) begin
					c = name_byte(k);
					if (ascii_lower(c) >= 8'h61 && ascii_lower(c) <= 8'h7A &&
							$urandom_range(0, 1) == 1)
						c = c ^ 8'h20;
					text_bytes.push_back(c);
				end
				if (n < span)
					text_bytes.push_back(name_byte(n) ^ 8'h01);
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) text_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
			end
			if ($urandom_range(0, 4) != 0)
				text_bytes.push_back(CH_COLON);
			n = $urandom_range(0, 2);
			repeat (n) text_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
			n = $urandom_range(0, 10);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0)
					text_bytes.push_back(8'($urandom_range(0, 255)));
				else
					text_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end
			push_line_end();
		end
		if ($urandom_range(0, 5) != 0)
			push_line_end();
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, text_bytes.size());
			while (text_bytes.size() > n) void'(text_bytes.pop_back());
		end
	endfunction

	// The receiver switches between stall patterns at random times.
	rx_mode_t    rx_mode = RX_STEADY;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
		RX_STEADY:   m_axis_tready <= 1'b1;
		RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
		RX_PERIODIC: m_axis_tready <= ((rx_tick % 5) < 2);
		default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Result beats are checked at the falling edge, where every signal is settled for
	// the rising edge that accepts the beat.
	always @(negedge clk) begin
		header_beat_t seen, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
			beats_seen++;
			if (pending_beats.size() == 0) begin
				note_failure($sformatf("beat %0d arrived with nothing expected: %h",
					beats_seen, seen));
			end else begin
				want = pending_beats.pop_front();
				if (seen !== want)
					note_failure($sformatf({"beat %0d (expected/actual): value_byte %h/%h ",
						"byte_valid %b/%b search_done %b/%b header_found %b/%b"},
						beats_seen, want.value_byte, seen.value_byte,
						want.byte_valid, seen.byte_valid, want.search_done,
						seen.search_done, want.header_found, seen.header_found));
			end
		end
	end

	initial begin
		int unsigned phase_no, phase_mark, pick, k;
		logic [4:0]   len;
		logic [127:0] chars;
		logic [7:0]   c;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script. Names are only loaded once the block has gone quiet.
		foreach (script[i]) begin
			if (script[i].load) begin
				quiesce();
				load_name(script[i].len, script[i].chars_lo, script[i].chars_hi);
			end else begin
				send_text_byte(script[i].text, script[i].last, script[i].typed, script[i].want);
			end
		end

		// Random header blocks, in phases that each run under one name setting. The
		// first phases take the extremes of the length field and of the characters.
		live_bytes = 0;
		phase_no = 0;
		while (live_bytes < RANDOM_TARGET) begin
			quiesce();
			pick = $urandom_range(0, 9);
			case (phase_no)
			0: len = 5'd16;
			1: len = 5'd31;
			2: len = 5'd0;
			3: len = 5'd1;
			default: begin
				if (pick == 0)
					len = 5'd0;
				else if (pick == 1)
					len = 5'd1;
				else if (pick == 2)
					len = 5'd16;
				else if (pick == 3)
					len = 5'($urandom_range(17, 31));
				else
					len = 5'($urandom_range(2, 15));
			end
			endcase
			for (k = 0; k < MAX_NAME_LEN; k++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					c = ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
				else if (pick <= 3)
					c = 8'($urandom_range(0, 255));
				else if (pick == 4)
					c = 8'h2D;
				else
					c = 8'($urandom_range(8'h61, 8'h7A)) ^ (($urandom_range(0, 1) == 1) ? 8'h20 : 8'h00);
				chars[8 * k +: 8] = c;
			end
			if (phase_no == 1)
				chars = '1;
			if (phase_no == 3)
				chars = '0;
			load_name(len, chars[63:0], chars[127:64]);
			phase_no++;

			phase_mark = live_bytes;
			while (live_bytes - phase_mark < PHASE_BYTES && live_bytes < RANDOM_TARGET) begin
				compose_text();
				foreach (text_bytes[i]) begin
					// Now and then the sender holds off until the results have drained.
					if ($urandom_range(0, 63) == 0)
						quiesce();
					send_text_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_BEAT);
				end
			end
		end

		quiesce();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/mhve_pkg.sv
design/mhve_step.sv
design/mail_header_value_extractor.sv
test/testbench.sv
